// ----- hw/rtl/chacha20_stream_cipher_core_defines.svh -----
// Assertion macros shared by the checker files of the stream cipher core.
// No dependencies; include by bare file name.
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CC20_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and functions of the ChaCha20 stream cipher core.
// No dependencies; imported by cc20_core, chacha20_stream_cipher_core and tb_top.
package cc20_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;

  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  localparam logic [4:0] ROT_A1 = 5'd16;
  localparam logic [4:0] ROT_A2 = 5'd12;
  localparam logic [4:0] ROT_B1 = 5'd8;
  localparam logic [4:0] ROT_B2 = 5'd7;

  localparam int unsigned CHUNK_BYTES = 8;
  localparam logic [3:0]  CNT_FULL    = 4'd8;

  // Register map, index = paddr[5:3]
  localparam logic [2:0] REG_KEY0      = 3'd0;
  localparam logic [2:0] REG_KEY1      = 3'd1;
  localparam logic [2:0] REG_KEY2      = 3'd2;
  localparam logic [2:0] REG_KEY3      = 3'd3;
  localparam logic [2:0] REG_NONCE_LO  = 3'd4;
  localparam logic [2:0] REG_NONCE_HI  = 3'd5;
  localparam logic [2:0] REG_CTR_INIT  = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_BLOCK
  } ctl_state_e;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_QRA,
    UOP_QRB,
    UOP_FEED
  } uop_e;

  typedef struct packed {
    uop_e       op;
    logic       diag;
    logic       loop;
    logic       fin;
    logic [2:0] target;
  } ucw_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cc20_stat_t;

  localparam logic [2:0] UC_ENTRY = 3'd0;
  localparam logic [2:0] UC_LOOP  = 3'd1;

  // Block program: load, column and diagonal half rounds, loop, feed-forward.
  function automatic ucw_t uc_rom(logic [2:0] step);
    ucw_t w;
    w = '{op: UOP_NOP, diag: 1'b0, loop: 1'b0, fin: 1'b1, target: UC_ENTRY};
    case (step)
      3'd0: w = '{op: UOP_LOAD, diag: 1'b0, loop: 1'b0, fin: 1'b0, target: UC_ENTRY};
      3'd1: w = '{op: UOP_QRA,  diag: 1'b0, loop: 1'b0, fin: 1'b0, target: UC_ENTRY};
      3'd2: w = '{op: UOP_QRB,  diag: 1'b0, loop: 1'b0, fin: 1'b0, target: UC_ENTRY};
      3'd3: w = '{op: UOP_QRA,  diag: 1'b1, loop: 1'b0, fin: 1'b0, target: UC_ENTRY};
      3'd4: w = '{op: UOP_QRB,  diag: 1'b1, loop: 1'b1, fin: 1'b0, target: UC_LOOP};
      3'd5: w = '{op: UOP_FEED, diag: 1'b0, loop: 1'b0, fin: 1'b1, target: UC_ENTRY};
      default: w = '{op: UOP_NOP, diag: 1'b0, loop: 1'b0, fin: 1'b1, target: UC_ENTRY};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // Half a quarter round: [0]=a, [1]=b, [2]=c, [3]=d.
  function automatic logic [3:0][31:0] qr_half(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d,
                                               logic second);
    logic [31:0] na, nb, nc, nd;
    logic [4:0]  r1, r2;
    r1 = second ? ROT_B1 : ROT_A1;
    r2 = second ? ROT_B2 : ROT_A2;
    na = a + b;
    nd = rotl32(d ^ na, r1);
    nc = c + nd;
    nb = rotl32(b ^ nc, r2);
    return {nd, nc, nb, na};
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] cnt);
    logic [63:0] m;
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      m[8*j +: 8] = (4'(j) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/cc20_core.sv -----
// Microcoded ChaCha20 block engine: four half-quarter-round lanes driven by
// a control ROM, step counter and round loop. Depends on cc20_pkg.
module cc20_core
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0][31:0] init_i,
  output logic [15:0][31:0] ks_o,
  output cc20_stat_t        stat_o
);

  localparam int unsigned RndW = $clog2(DOUBLE_ROUNDS);
  localparam logic [RndW-1:0] RndLast = RndW'(DOUBLE_ROUNDS - 1);

  logic [15:0][31:0] x_q, x_d;
  logic [2:0]        step_q, step_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  ucw_t              uc;

  always_comb begin
    logic [1:0]       lb, lc, ld;
    logic [3:0]       ia, ib, ic, id;
    logic [3:0][31:0] qv;
    lb     = '0;
    lc     = '0;
    ld     = '0;
    ia     = '0;
    ib     = '0;
    ic     = '0;
    id     = '0;
    qv     = '0;
    uc     = uc_rom(step_q);
    x_d    = x_q;
    step_d = step_q;
    rnd_d  = rnd_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i && !run_q) begin
      run_d  = 1'b1;
      step_d = UC_ENTRY;
    end else if (run_q) begin
      case (uc.op)
        UOP_LOAD: begin
          x_d   = init_i;
          rnd_d = '0;
        end
        UOP_QRA, UOP_QRB: begin
          // lanes touch disjoint words, diagonal shifts rows b, c, d
          for (int l = 0; l < 4; l++) begin
            lb = 2'(l) + (uc.diag ? 2'd1 : 2'd0);
            lc = 2'(l) + (uc.diag ? 2'd2 : 2'd0);
            ld = 2'(l) + (uc.diag ? 2'd3 : 2'd0);
            ia = {2'd0, 2'(l)};
            ib = {2'd1, lb};
            ic = {2'd2, lc};
            id = {2'd3, ld};
            qv = qr_half(x_q[ia], x_q[ib], x_q[ic], x_q[id], uc.op == UOP_QRB);
            x_d[ia] = qv[0];
            x_d[ib] = qv[1];
            x_d[ic] = qv[2];
            x_d[id] = qv[3];
          end
        end
        UOP_FEED: begin
          for (int k = 0; k < 16; k++) begin
            x_d[k] = x_q[k] + init_i[k];
          end
        end
        default: ;
      endcase
      if (uc.fin) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (uc.loop && (rnd_q != RndLast)) begin
        rnd_d  = rnd_q + 1'b1;
        step_d = uc.target;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= UC_ENTRY;
      rnd_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign ks_o        = x_q;
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

endmodule

// ----- hw/rtl/chacha20_stream_cipher_core.sv -----
// ChaCha20 stream cipher (32-bit counter, 96-bit nonce), eight bytes per request.
// The first request of each 64-byte block starts the block engine: load, then
// 4*DOUBLE_ROUNDS half-quarter-round steps on four lanes, then the feed-forward,
// so its result is registered when the engine signals done, and the next request
// is taken only once the control is back in idle; the other seven requests of the
// block are served from the held keystream without the engine. One request is in
// flight at a time; the output register holds a result while the next request is
// taken. Key, nonce and initial counter sit on an APB-style port at byte address
// 8*index. Depends on cc20_pkg and cc20_core.
module chacha20_stream_cipher_core
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_bytes_o,
  output logic [3:0]  result_count_o,
  output logic        result_last_o
);

  logic [3:0][63:0]  key_q;
  logic [63:0]       nonce_lo_q;
  logic [31:0]       nonce_hi_q;
  logic [31:0]       ctr_init_q;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  ctl_state_e        state_q, state_d;
  logic              in_msg_q, in_msg_d;
  logic [2:0]        chunk_q, chunk_d;
  logic [31:0]       ctr_q, ctr_d;
  logic [63:0]       data_q, data_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       res_bytes_q, res_bytes_d;
  logic [3:0]        res_cnt_q, res_cnt_d;
  logic              res_last_q, res_last_d;

  logic [15:0][31:0] init_w;
  logic [15:0][31:0] ks;
  cc20_stat_t        eng_stat;
  logic              eng_start;
  logic              slot_free;
  logic              in_acc;
  logic [3:0]        cnt_sat;
  logic [2:0]        chunk_eff;
  logic [31:0]       ctr_eff;
  logic [63:0]       ks_chunk;
  logic [63:0]       ks_first;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
      ctr_init_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY0:     key_q[0]   <= pwdata;
        REG_KEY1:     key_q[1]   <= pwdata;
        REG_KEY2:     key_q[2]   <= pwdata;
        REG_KEY3:     key_q[3]   <= pwdata;
        REG_NONCE_LO: nonce_lo_q <= pwdata;
        REG_NONCE_HI: nonce_hi_q <= pwdata[31:0];
        REG_CTR_INIT: ctr_init_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY0:     prdata = key_q[0];
      REG_KEY1:     prdata = key_q[1];
      REG_KEY2:     prdata = key_q[2];
      REG_KEY3:     prdata = key_q[3];
      REG_NONCE_LO: prdata = nonce_lo_q;
      REG_NONCE_HI: prdata = {32'd0, nonce_hi_q};
      REG_CTR_INIT: prdata = {32'd0, ctr_init_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------- block engine ----------------
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]       = SIGMA[i];
      init_w[4 + 2*i] = key_q[i][31:0];
      init_w[5 + 2*i] = key_q[i][63:32];
    end
    init_w[12] = ctr_q;
    init_w[13] = nonce_lo_q[31:0];
    init_w[14] = nonce_lo_q[63:32];
    init_w[15] = nonce_hi_q;
  end

  cc20_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(eng_start),
    .init_i (init_w),
    .ks_o   (ks),
    .stat_o (eng_stat)
  );

  // ---------------- request control ----------------
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || eng_stat.busy || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_sat    = byte_count_i[3] ? CNT_FULL : byte_count_i;
  assign chunk_eff  = in_msg_q ? chunk_q : 3'd0;
  assign ctr_eff    = in_msg_q ? ctr_q : ctr_init_q;
  assign ks_chunk   = {ks[{chunk_eff, 1'b1}], ks[{chunk_eff, 1'b0}]};
  assign ks_first   = {ks[1], ks[0]};

  always_comb begin
    state_d     = state_q;
    in_msg_d    = in_msg_q;
    chunk_d     = chunk_q;
    ctr_d       = ctr_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    eng_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    res_bytes_d = res_bytes_q;
    res_cnt_d   = res_cnt_q;
    res_last_d  = res_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d   = data_bytes_i;
          cnt_d    = cnt_sat;
          last_d   = last_i;
          ctr_d    = ctr_eff;
          in_msg_d = !last_i;
          chunk_d  = last_i ? 3'd0 : chunk_eff + 3'd1;
          if (chunk_eff == 3'd0) begin
            // new block: hold the request until the engine is done
            eng_start = 1'b1;
            state_d   = ST_BLOCK;
          end else begin
            out_valid_d = 1'b1;
            res_bytes_d = (data_bytes_i ^ ks_chunk) & byte_mask(cnt_sat);
            res_cnt_d   = cnt_sat;
            res_last_d  = last_i;
          end
        end
      end
      ST_BLOCK: begin
        if (eng_stat.done) begin
          out_valid_d = 1'b1;
          res_bytes_d = (data_q ^ ks_first) & byte_mask(cnt_q);
          res_cnt_d   = cnt_q;
          res_last_d  = last_q;
          ctr_d       = ctr_q + 32'd1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      chunk_q     <= 3'd0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      chunk_q     <= chunk_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q      <= data_d;
    cnt_q       <= cnt_d;
    last_q      <= last_d;
    res_bytes_q <= res_bytes_d;
    res_cnt_q   <= res_cnt_d;
    res_last_q  <= res_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_bytes_o = res_bytes_q;
  assign result_count_o = res_cnt_q;
  assign result_last_o  = res_last_q;

endmodule

// ----- hw/rtl/cc20_chk.sv -----
// Port-level checker for the ChaCha20 stream cipher core, bound to the top level.
// Depends on chacha20_stream_cipher_core_defines.svh.
`include "chacha20_stream_cipher_core_defines.svh"

module cc20_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_bytes_o,
  input logic [3:0]  result_count_o
);

  // hold a stalled result
  `CC20_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_bytes_o), "stalled result changed")

  // never take a request while the result slot is blocked
  `CC20_ASSERT_SAME(a_in_blocked, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o, "request taken while output blocked")

  `CC20_ASSERT_SAME(a_cnt_range, clk_i, rst_ni, out_valid_o, result_count_o <= 4'd8, "result count above eight")

  // drop bytes beyond the count
  `CC20_ASSERT_SAME(a_tail_zero, clk_i, rst_ni, out_valid_o, (result_bytes_o >> {result_count_o, 3'b000}) == 64'd0, "unused result bytes not zero")

endmodule

bind chacha20_stream_cipher_core cc20_chk u_cc20_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_bytes_o(result_bytes_o),
  .result_count_o(result_count_o)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for chacha20_stream_cipher_core: keystream XOR of eight-byte requests.
// Needs cc20_pkg for the register indexes; predicts every result with its own ChaCha20 block
// function and compares each accepted result against the oldest prediction.
module tb_top
  import cc20_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DBL_ROUNDS = 10;
  localparam int ITEMS      = 550;
  localparam int WATCHDOG   = 4000;
  localparam int SETTLE     = 4;
  localparam int BLOCK_LAT  = 4 * DBL_ROUNDS + 8;

  localparam logic [2:0]  REG_UNUSED = 3'd7;
  localparam logic [31:0] CHACHA_C0  = 32'h61707865;
  localparam logic [31:0] CHACHA_C1  = 32'h3320646e;
  localparam logic [31:0] CHACHA_C2  = 32'h79622d32;
  localparam logic [31:0] CHACHA_C3  = 32'h6b206574;

  typedef logic [15:0][31:0] chacha_state_t;
  typedef logic [7:0][63:0]  keystream_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        lst;
  } plain_req_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        lst;
  } cipher_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_bytes_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_bytes_o;
  logic [3:0]  result_count_o;
  logic        result_last_o;

  chacha20_stream_cipher_core #(
    .DOUBLE_ROUNDS(DBL_ROUNDS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_bytes_i   (data_bytes_i),
    .byte_count_i   (byte_count_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_bytes_o (result_bytes_o),
    .result_count_o (result_count_o),
    .result_last_o  (result_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror
  logic [3:0][63:0] key_mirror = '0;
  logic [63:0]      nonce_lo_mirror = '0;
  logic [31:0]      nonce_hi_mirror = '0;
  logic [31:0]      ctr_init_mirror = '0;

  // cipher state as the block should hold it
  keystream_t  ks_blk = '0;
  logic [31:0] blk_ctr = '0;
  logic [2:0]  chunk_idx = '0;
  logic        msg_open = 1'b0;

  plain_req_t  plain_req_q[$];
  cipher_res_t cipher_exp_q[$];
  plain_req_t  cur_req;
  int          errors = 0;
  int          n_items = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [31:0] stall_pat = '0;
  int          idle_cycles = 0;

  function automatic logic [31:0] rotate_left(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic chacha_state_t qr_mix(chacha_state_t s, int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rotate_left(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotate_left(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotate_left(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotate_left(s[b] ^ s[c], 7);
    return s;
  endfunction

  function automatic keystream_t chacha_keystream(logic [31:0] ctr);
    chacha_state_t init;
    chacha_state_t x;
    keystream_t    blk;
    init[0] = CHACHA_C0;
    init[1] = CHACHA_C1;
    init[2] = CHACHA_C2;
    init[3] = CHACHA_C3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_mirror[i][31:0];
      init[5 + 2 * i] = key_mirror[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_lo_mirror[31:0];
    init[14] = nonce_lo_mirror[63:32];
    init[15] = nonce_hi_mirror;
    x = init;
    for (int r = 0; r < DBL_ROUNDS; r++) begin
      x = qr_mix(x, 0, 4, 8, 12);
      x = qr_mix(x, 1, 5, 9, 13);
      x = qr_mix(x, 2, 6, 10, 14);
      x = qr_mix(x, 3, 7, 11, 15);
      x = qr_mix(x, 0, 5, 10, 15);
      x = qr_mix(x, 1, 6, 11, 12);
      x = qr_mix(x, 2, 7, 8, 13);
      x = qr_mix(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) begin
      blk[i] = {x[2 * i + 1] + init[2 * i + 1], x[2 * i] + init[2 * i]};
    end
    return blk;
  endfunction

  // Advance the cipher state by one request and return its result.
  function automatic cipher_res_t encrypt_chunk(plain_req_t req);
    cipher_res_t res;
    logic [3:0]  n;
    logic [63:0] mask;
    n = (req.cnt > 4'd8) ? 4'd8 : req.cnt;
    if (!msg_open) begin
      blk_ctr = ctr_init_mirror;
      chunk_idx = '0;
      msg_open = 1'b1;
    end
    if (chunk_idx == 3'd0) begin
      ks_blk = chacha_keystream(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
    end
    mask = (n == 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    res.data = (req.data ^ ks_blk[chunk_idx]) & mask;
    res.cnt = n;
    res.lst = req.lst;
    if (req.lst) begin
      msg_open = 1'b0;
      chunk_idx = '0;
    end else begin
      chunk_idx = chunk_idx + 3'd1;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_req(logic [63:0] data, logic [3:0] cnt, logic lst);
    plain_req_t req;
    req.data = data;
    req.cnt = cnt;
    req.lst = lst;
    plain_req_q.push_back(req);
    n_items++;
  endtask

  // Clean messages are full chunks with a short tail; noisy ones get any count and may lack
  // their last flag so the message runs on into the next.
  task automatic add_message(int len, bit clean);
    logic [3:0] cnt;
    logic       lst;
    for (int k = 0; k < len; k++) begin
      if (clean) begin
        cnt = (k == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
        lst = (k == len - 1);
      end else begin
        cnt = 4'($urandom_range(0, 15));
        lst = (k == len - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
      end
      push_req(rand_data(), cnt, lst);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY0:     key_mirror[0] = val;
      REG_KEY1:     key_mirror[1] = val;
      REG_KEY2:     key_mirror[2] = val;
      REG_KEY3:     key_mirror[3] = val;
      REG_NONCE_LO: nonce_lo_mirror = val;
      REG_NONCE_HI: nonce_hi_mirror = val[31:0];
      REG_CTR_INIT: ctr_init_mirror = val[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (plain_req_q.size() != 0 || in_valid_i || cipher_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_random_config(bit every);
    logic [63:0] val;
    for (int i = 0; i <= 7; i++) begin
      if (every || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0: val = '0;
          1: val = '1;
          default: val = {$urandom, $urandom};
        endcase
        // park the counter near the wrap now and then
        if (3'(i) == REG_CTR_INIT && $urandom_range(0, 3) == 0)
          val[31:0] = 32'hffffffff - 32'($urandom_range(0, 3));
        if (3'(i) != REG_UNUSED || $urandom_range(0, 3) == 0)
          reg_write(3'(i), val);
      end
    end
  endtask

  // request driver: bursts of random length, random gaps in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        cipher_exp_q.push_back(encrypt_chunk(cur_req));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (plain_req_q.size() != 0) begin
          cur_req = plain_req_q.pop_front();
          in_valid_i <= 1'b1;
          data_bytes_i <= cur_req.data;
          byte_count_i <= cur_req.cnt;
          last_i <= cur_req.lst;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    cipher_res_t want;
    logic        stall_nxt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cipher_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result bytes %h count %0d last %b", $realtime,
                   result_bytes_o, result_count_o, result_last_o);
        end else begin
          want = cipher_exp_q.pop_front();
          if (result_bytes_o !== want.data) begin
            errors++;
            $display("%0t: result_bytes expected %h got %h", $realtime, want.data,
                     result_bytes_o);
          end
          if (result_count_o !== want.cnt) begin
            errors++;
            $display("%0t: result_count expected %0d got %0d", $realtime, want.cnt,
                     result_count_o);
          end
          if (result_last_o !== want.lst) begin
            errors++;
            $display("%0t: result_last expected %b got %b", $realtime, want.lst,
                     result_last_o);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
        stall_pat = $urandom;
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: stall_nxt = 1'b0;
        1: stall_nxt = ($urandom_range(0, 3) == 0);
        2: stall_nxt = stall_pat[stall_left % 32];
        default: stall_nxt = ($urandom_range(0, 1) == 0);
      endcase
      out_stall_i <= stall_nxt;
    end
  end

  // progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no request or result moved for %0d cycles", $realtime, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int phase_len;
    int start_items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: field extremes, odd counts, short request before last, block crossing.
    push_req('0, 4'd8, 1'b0);
    push_req('1, 4'd8, 1'b0);
    push_req(rand_data(), 4'd0, 1'b0);
    push_req(rand_data(), 4'd9, 1'b0);
    push_req(rand_data(), 4'd15, 1'b0);
    push_req(rand_data(), 4'd1, 1'b0);
    push_req('1, 4'd3, 1'b0);
    push_req(rand_data(), 4'd8, 1'b0);
    push_req(rand_data(), 4'd4, 1'b1);
    wait_idle();

    // All ones everywhere: the second block wraps the counter to zero.
    for (int i = 0; i <= 7; i++) reg_write(3'(i), '1);
    for (int k = 0; k < 9; k++) push_req((k % 2) ? '1 : '0, 4'd8, k == 8);
    push_req(rand_data(), 4'd5, 1'b1);
    // stop mid-message, then change key, nonce and start counter underneath it
    push_req(rand_data(), 4'd8, 1'b0);
    push_req(rand_data(), 4'd8, 1'b0);
    wait_idle();
    reg_write(REG_KEY1, {$urandom, $urandom});
    reg_write(REG_NONCE_HI, {$urandom, $urandom});
    reg_write(REG_CTR_INIT, 64'd5);
    for (int k = 0; k < 7; k++) push_req(rand_data(), 4'd8, k == 6);
    push_req(rand_data(), 4'd7, 1'b1);
    wait_idle();

    set_random_config(1'b1);
    while (n_items < ITEMS) begin
      start_items = n_items;
      phase_len = $urandom_range(20, 80);
      while (n_items - start_items < phase_len) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: add_message($urandom_range(1, 10), 1'b0);
          4, 5, 6, 7, 8: add_message($urandom_range(9, 24), 1'b1);
          9: add_message($urandom_range(25, 40), 1'b1);
          default: add_message($urandom_range(1, 10), 1'b1);
        endcase
      end
      // hold the sender until every result is back
      wait_idle();
      if ($urandom_range(0, 2) != 0) set_random_config(1'b0);
    end

    wait_idle();
    repeat (BLOCK_LAT) @(posedge clk_i);
    if (cipher_exp_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $realtime, cipher_exp_q.size());
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
